// File: rtl/core/tsim_pkg.sv
// ----------------------------------------------------------------------------
// tsim_pkg
// Shared types and constants of the track sector interleave map.
// ----------------------------------------------------------------------------
package tsim_pkg;

  localparam int MAX_SECTORS = 16;
  localparam int SLOT_W      = $clog2(MAX_SECTORS);
  localparam int SEC_W       = 5;
  localparam int CYL_W       = 8;
  localparam int STEP_W      = 4;
  localparam int SKEW_W      = 4;
  localparam int SIZE_W      = 2;
  localparam int CFG_VAL_W   = 8;
  // dividend of the start slot reduction: cylinder times skew
  localparam int DIVD_W      = CYL_W + SKEW_W;
  localparam int DIVC_W      = $clog2(DIVD_W);

  localparam logic [SEC_W-1:0]  RST_SECTORS    = 5'd9;
  localparam logic [STEP_W-1:0] RST_INTERLEAVE = 4'd4;
  localparam logic [SKEW_W-1:0] RST_SKEW       = 4'd0;
  localparam logic [SIZE_W-1:0] RST_SIZE       = 2'd2;

  typedef enum logic [1:0] {
    REG_SECTORS    = 2'd0,
    REG_INTERLEAVE = 2'd1,
    REG_SKEW       = 2'd2,
    REG_SIZE       = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_DIV   = 2'd1,
    ST_PLACE = 2'd2,
    ST_EMIT  = 2'd3
  } tsim_state_e;

  typedef struct packed {
    cfg_reg_e               index;
    logic [CFG_VAL_W-1:0]   value;
  } cfg_data_t;

  typedef struct packed {
    logic [CYL_W-1:0] cylinder;
    logic             head;
  } in_data_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot_index;
    logic [CYL_W-1:0]  id_cylinder;
    logic              id_head;
    logic [SEC_W-1:0]  sector_number;
    logic [SIZE_W-1:0] id_size;
    logic              last_entry;
  } out_data_t;

  typedef struct packed {
    logic start;
    logic div_step;
    logic place;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic n_zero;
    logic div_last;
    logic cur_taken;
    logic place_last;
    logic out_free;
    logic emit_last;
  } dp_status_t;

endpackage

// File: rtl/core/tsim_if.sv
// ----------------------------------------------------------------------------
// tsim_if
// Valid/ready channels of the track sector interleave map.
// ----------------------------------------------------------------------------
interface tsim_cfg_if import tsim_pkg::*; ();
  logic      valid;
  logic      ready;
  cfg_data_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface tsim_in_if import tsim_pkg::*; ();
  logic     valid;
  logic     ready;
  in_data_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface tsim_out_if import tsim_pkg::*; ();
  logic      valid;
  logic      ready;
  out_data_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/core/track_sector_interleave_map.sv
// ----------------------------------------------------------------------------
// track_sector_interleave_map
// Builds the ID table of one track from a cylinder/head request.
// ----------------------------------------------------------------------------
// One request is worked at a time. After the request beat the start slot and
// the reduced interleave come out of a bit-serial remainder unit, then each
// sector is placed at the next free slot, probing occupied slots one at a
// time, then one entry beat per slot leaves through a registered output
// (one per cycle when the sink is ready). The number of probes is set by
// interleave and N, at most N*(N-1)/2 for a track of N sectors. The next
// request is taken once the last entry is in the output register. With zero
// sectors configured a request is taken and yields no entries. Config writes
// are always ready and apply at once.
// ----------------------------------------------------------------------------
module track_sector_interleave_map import tsim_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  tsim_cfg_if.sink   cfg_i,
  tsim_in_if.sink    in_i,
  tsim_out_if.source out_o
);

  dp_cmd_t    cmd;
  dp_status_t sts;

  assign cfg_i.ready = 1'b1;

  tsim_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tsim_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_i.valid),
    .cfg_data_i  (cfg_i.data),
    .in_data_i   (in_i.data),
    .out_ready_i (out_o.ready),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_o.valid),
    .out_data_o  (out_o.data)
  );

endmodule

// File: rtl/core/tsim_ctrl.sv
// ----------------------------------------------------------------------------
// tsim_ctrl
// Sequencer: start, modulo reduction, sector placement, entry emission.
// ----------------------------------------------------------------------------
module tsim_ctrl import tsim_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dp_status_t sts_i,
  output dp_cmd_t    cmd_o
);

  tsim_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          // zero sectors: beat is taken, nothing is produced
          if (!sts_i.n_zero) begin
            state_d = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = ST_PLACE;
        end
      end
      ST_PLACE: begin
        cmd_o.place = 1'b1;
        if (!sts_i.cur_taken && sts_i.place_last) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.emit_last) begin
            state_d = ST_IDLE;
          end
        end
      end
    endcase
  end

endmodule

// File: rtl/core/tsim_dp.sv
// ----------------------------------------------------------------------------
// tsim_dp
// Datapath: config registers, serial remainder unit, slot map, output register.
// ----------------------------------------------------------------------------
module tsim_dp import tsim_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  cfg_data_t  cfg_data_i,
  input  in_data_t   in_data_i,
  input  logic       out_ready_i,
  input  dp_cmd_t    cmd_i,
  output dp_status_t sts_o,
  output logic       out_valid_o,
  output out_data_t  out_data_o
);

  logic [SEC_W-1:0]  spt_q;
  logic [STEP_W-1:0] ilv_q;
  logic [SKEW_W-1:0] skew_q;
  logic [SIZE_W-1:0] size_q;

  logic [CYL_W-1:0]  cyl_q;
  logic              head_q;
  logic [SEC_W-1:0]  n_q;
  logic [SEC_W-1:0]  n_sat;

  logic [DIVD_W-1:0] dvd_a_q, dvd_b_q;
  logic [SLOT_W-1:0] rem_a_q, rem_b_q;
  logic [SLOT_W-1:0] rem_a_d, rem_b_d;
  logic [SEC_W-1:0]  trial_a, trial_b;
  logic [DIVC_W-1:0] div_cnt_q;

  logic [SLOT_W-1:0] slot_q, stepm_q;
  logic [SLOT_W-1:0] slot_inc, slot_adv;
  logic [SEC_W-1:0]  slot_sum;
  logic [SEC_W-1:0]  sec_q;
  logic [SLOT_W-1:0] emit_q;

  logic [MAX_SECTORS-1:0] taken_q;
  logic [SEC_W-1:0]       sector_q [MAX_SECTORS];

  logic      out_vld_q;
  out_data_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spt_q  <= RST_SECTORS;
      ilv_q  <= RST_INTERLEAVE;
      skew_q <= RST_SKEW;
      size_q <= RST_SIZE;
    end else if (cfg_we_i) begin
      unique case (cfg_data_i.index)
        REG_SECTORS:    spt_q  <= cfg_data_i.value[SEC_W-1:0];
        REG_INTERLEAVE: ilv_q  <= cfg_data_i.value[STEP_W-1:0];
        REG_SKEW:       skew_q <= cfg_data_i.value[SKEW_W-1:0];
        REG_SIZE:       size_q <= cfg_data_i.value[SIZE_W-1:0];
      endcase
    end
  end

  assign n_sat = (spt_q > SEC_W'(MAX_SECTORS)) ? SEC_W'(MAX_SECTORS) : spt_q;

  // restoring remainder, one dividend bit per cycle, two lanes sharing n
  assign trial_a = {rem_a_q, dvd_a_q[DIVD_W-1]};
  assign trial_b = {rem_b_q, dvd_b_q[DIVD_W-1]};
  assign rem_a_d = (trial_a >= n_q) ? SLOT_W'(trial_a - n_q) : SLOT_W'(trial_a);
  assign rem_b_d = (trial_b >= n_q) ? SLOT_W'(trial_b - n_q) : SLOT_W'(trial_b);

  // slot moves: one on with wrap, or by the reduced interleave with wrap
  assign slot_inc = ({1'b0, slot_q} == n_q - SEC_W'(1)) ? '0 : slot_q + SLOT_W'(1);
  assign slot_sum = {1'b0, slot_q} + {1'b0, stepm_q};
  assign slot_adv = (slot_sum >= n_q) ? SLOT_W'(slot_sum - n_q) : SLOT_W'(slot_sum);

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      cyl_q     <= in_data_i.cylinder;
      head_q    <= in_data_i.head;
      n_q       <= n_sat;
      dvd_a_q   <= DIVD_W'(in_data_i.cylinder) * DIVD_W'(skew_q);
      dvd_b_q   <= DIVD_W'(ilv_q);
      rem_a_q   <= '0;
      rem_b_q   <= '0;
      div_cnt_q <= '0;
      sec_q     <= SEC_W'(1);
      emit_q    <= '0;
    end
    if (cmd_i.div_step) begin
      dvd_a_q   <= dvd_a_q << 1;
      dvd_b_q   <= dvd_b_q << 1;
      rem_a_q   <= rem_a_d;
      rem_b_q   <= rem_b_d;
      div_cnt_q <= div_cnt_q + DIVC_W'(1);
      if (sts_o.div_last) begin
        slot_q  <= rem_a_d;
        stepm_q <= rem_b_d;
      end
    end
    if (cmd_i.place) begin
      if (taken_q[slot_q]) begin
        slot_q <= slot_inc;
      end else begin
        sector_q[slot_q] <= sec_q;
        slot_q           <= slot_adv;
        sec_q            <= sec_q + SEC_W'(1);
      end
    end
    if (cmd_i.emit) begin
      out_q.slot_index    <= emit_q;
      out_q.id_cylinder   <= cyl_q;
      out_q.id_head       <= head_q;
      out_q.sector_number <= sector_q[emit_q];
      out_q.id_size       <= size_q;
      out_q.last_entry    <= sts_o.emit_last;
      emit_q              <= emit_q + SLOT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      taken_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (cmd_i.start && (n_sat != '0)) begin
        taken_q <= '0;
      end else if (cmd_i.place && !taken_q[slot_q]) begin
        taken_q[slot_q] <= 1'b1;
      end
      if (cmd_i.emit) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign sts_o.n_zero     = (spt_q == '0);
  assign sts_o.div_last   = (div_cnt_q == DIVC_W'(DIVD_W - 1));
  assign sts_o.cur_taken  = taken_q[slot_q];
  assign sts_o.place_last = (sec_q == n_q);
  assign sts_o.out_free   = !out_vld_q || out_ready_i;
  assign sts_o.emit_last  = ({1'b0, emit_q} == n_q - SEC_W'(1));

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

// File: tb/sv/track_sector_interleave_map_tb.sv
// ----------------------------------------------------------------------------
// track_sector_interleave_map_tb
// Self-checking bench for the track format table builder. Requests carry a
// cylinder and a head; a scoreboard class rebuilds each track's slot order
// from the register settings it sees written and checks every entry beat in
// order. Register writes happen only with the block drained. Both channels
// idle and stall in random bursts, except in the closing phases.
// ----------------------------------------------------------------------------
module track_sector_interleave_map_tb import tsim_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 4000;
  // longest track: setup, placement with every probe, emit
  localparam int DRAIN_CYCLES   = 200;

  class track_table_sb;
    logic [SEC_W-1:0]  sectors;
    logic [STEP_W-1:0] step;
    logic [SKEW_W-1:0] skew;
    logic [SIZE_W-1:0] size;
    bit                slot_taken [MAX_SECTORS];
    logic [SEC_W-1:0]  slot_sector[MAX_SECTORS];
    out_data_t         entry_q[$];
    int                errors;

    function new();
      sectors = RST_SECTORS;
      step    = RST_INTERLEAVE;
      skew    = RST_SKEW;
      size    = RST_SIZE;
      errors  = 0;
      foreach (slot_taken[k]) begin
        slot_taken[k]  = 1'b0;
        slot_sector[k] = '0;
      end
    endfunction

    function void apply_reg(cfg_data_t w);
      case (w.index)
        REG_SECTORS:    sectors = w.value[SEC_W-1:0];
        REG_INTERLEAVE: step    = w.value[STEP_W-1:0];
        REG_SKEW:       skew    = w.value[SKEW_W-1:0];
        REG_SIZE:       size    = w.value[SIZE_W-1:0];
        default: ;
      endcase
    endfunction

    // lay out one track and queue its entries in slot order
    function void note_request(in_data_t req);
      int        n;
      int        slot;
      out_data_t e;
      n = int'(sectors);
      if (n == 0) return;
      if (n > MAX_SECTORS) n = MAX_SECTORS;
      for (int k = 0; k < n; k++) slot_taken[k] = 1'b0;
      slot = (int'(req.cylinder) * int'(skew)) % n;
      for (int sec = 1; sec <= n; sec++) begin
        while (slot_taken[slot]) slot = (slot + 1) % n;
        slot_taken[slot]  = 1'b1;
        slot_sector[slot] = SEC_W'(sec);
        slot = (slot + int'(step)) % n;
      end
      for (int k = 0; k < n; k++) begin
        e.slot_index    = SLOT_W'(k);
        e.id_cylinder   = req.cylinder;
        e.id_head       = req.head;
        e.sector_number = slot_sector[k];
        e.id_size       = size;
        e.last_entry    = (k == n - 1);
        entry_q.push_back(e);
      end
    endfunction

    function void cmp_field(string name, int unsigned exp_v, int unsigned got_v);
      if (exp_v !== got_v) begin
        errors++;
        $error("%s mismatch: expected %0d, got %0d", name, exp_v, got_v);
      end
    endfunction

    function void check_entry(out_data_t got);
      out_data_t exp_e;
      if (entry_q.size() == 0) begin
        errors++;
        $error("entry beat with nothing expected: slot %0d", got.slot_index);
        return;
      end
      exp_e = entry_q.pop_front();
      cmp_field("slot_index",    32'(exp_e.slot_index),    32'(got.slot_index));
      cmp_field("id_cylinder",   32'(exp_e.id_cylinder),   32'(got.id_cylinder));
      cmp_field("id_head",       32'(exp_e.id_head),       32'(got.id_head));
      cmp_field("sector_number", 32'(exp_e.sector_number), 32'(got.sector_number));
      cmp_field("id_size",       32'(exp_e.id_size),       32'(got.id_size));
      cmp_field("last_entry",    32'(exp_e.last_entry),    32'(got.last_entry));
    endfunction

    function int pending();
      return entry_q.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  tsim_cfg_if cfg_if ();
  tsim_in_if  in_if ();
  tsim_out_if out_if ();

  track_sector_interleave_map u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  track_table_sb sb = new();
  bit            sender_gaps = 1'b1;
  bit            sink_stalls = 1'b1;
  int            idle_cycles = 0;

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // monitors: every beat seen at the edge goes to the scoreboard
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_if.valid === 1'b1 && cfg_if.ready === 1'b1) sb.apply_reg(cfg_if.data);
      if (in_if.valid === 1'b1 && in_if.ready === 1'b1) sb.note_request(in_if.data);
      if (out_if.valid === 1'b1 && out_if.ready === 1'b1) sb.check_entry(out_if.data);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((cfg_if.valid === 1'b1 && cfg_if.ready === 1'b1) ||
          (in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
          (out_if.valid === 1'b1 && out_if.ready === 1'b1)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // entry sink: ready drops in bursts while stalls are enabled
  initial begin
    out_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (sink_stalls && $urandom_range(0, 4) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end else begin
        out_if.ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
    end
  end

  task automatic write_regs(logic [7:0] sec_v, logic [7:0] step_v,
                            logic [7:0] skew_v, logic [7:0] size_v);
    cfg_data_t w[4];
    w[0] = '{index: REG_SECTORS,    value: sec_v};
    w[1] = '{index: REG_INTERLEAVE, value: step_v};
    w[2] = '{index: REG_SKEW,       value: skew_v};
    w[3] = '{index: REG_SIZE,       value: size_v};
    foreach (w[i]) begin
      cfg_if.valid <= 1'b1;
      cfg_if.data  <= w[i];
      @(posedge clk_i);
      while (cfg_if.ready !== 1'b1) @(posedge clk_i);
    end
    cfg_if.valid <= 1'b0;
  endtask

  // valid stays high after the beat unless the next call opens a gap or a drain
  task automatic send_request(logic [CYL_W-1:0] cyl, logic head);
    if (sender_gaps && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      in_if.data  <= in_data_t'($urandom);
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= '{cylinder: cyl, head: head};
    @(posedge clk_i);
    while (in_if.ready !== 1'b1) @(posedge clk_i);
  endtask

  // sender holds off until the whole table is out, then lets the block settle
  task automatic drain_block();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic random_regs();
    int          pick;
    logic [4:0]  sec_f;
    pick = $urandom_range(0, 19);
    if (pick == 0)      sec_f = 5'd0;
    else if (pick == 1) sec_f = 5'($urandom_range(17, 31));
    else if (pick < 8)  sec_f = 5'($urandom_range(1, 4));
    else                sec_f = 5'($urandom_range(1, 16));
    write_regs({3'($urandom), sec_f}, 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  initial begin
    rst_ni       <= 1'b0;
    cfg_if.valid <= 1'b0;
    cfg_if.data  <= '{index: REG_SECTORS, value: '0};
    in_if.valid  <= 1'b0;
    in_if.data   <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: nine sectors, interleave four, no skew
    send_request(8'd0, 1'b0);
    send_request(8'd255, 1'b1);
    drain_block();

    // full track, top step and skew
    write_regs(8'hF0, 8'hFF, 8'hFF, 8'hFF);
    send_request(8'd255, 1'b1);
    send_request(8'd0, 1'b0);
    send_request(8'd1, 1'b0);
    send_request(8'd128, 1'b1);
    drain_block();

    // single sector track
    write_regs(8'h01, 8'h00, 8'h0F, 8'h00);
    send_request(8'd255, 1'b0);
    send_request(8'd7, 1'b1);
    drain_block();

    // zero sectors: requests are taken, nothing comes out
    write_regs(8'h00, 8'h03, 8'h05, 8'h01);
    send_request(8'd3, 1'b1);
    send_request(8'd200, 1'b0);
    drain_block();

    // sector count above the maximum saturates
    write_regs(8'hFF, 8'h00, 8'h01, 8'h01);
    send_request(8'd15, 1'b1);
    send_request(8'd0, 1'b0);
    drain_block();

    // zero interleave with skew
    write_regs(8'h0D, 8'h00, 8'h07, 8'h02);
    send_request(8'd100, 1'b0);
    send_request(8'd13, 1'b1);
    drain_block();

    // interleave larger than the track wraps
    write_regs(8'h05, 8'h0F, 8'h09, 8'h03);
    send_request(8'd255, 1'b1);
    send_request(8'd1, 1'b0);
    drain_block();

    // half-track step on a full track probes heavily
    write_regs(8'h10, 8'h08, 8'h04, 8'h00);
    send_request(8'd3, 1'b0);
    send_request(8'd170, 1'b1);
    drain_block();

    for (int phase = 0; phase < 12; phase++) begin
      if (phase >= 10) begin
        sender_gaps = 1'b0;
        sink_stalls = 1'b0;
      end
      random_regs();
      repeat (12) send_request(8'($urandom), 1'($urandom));
      drain_block();
    end

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: track_sector_interleave_map.f
rtl/core/tsim_pkg.sv
rtl/core/tsim_if.sv
rtl/core/tsim_ctrl.sv
rtl/core/tsim_dp.sv
rtl/core/track_sector_interleave_map.sv
tb/sv/track_sector_interleave_map_tb.sv
